// ===== hdl/sit_pkg.sv =====
// Shared types and constants for the segment intersection test.
// No dependencies; compile this file first.
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    // Sign of one cross product, encoded as the orientation of three points.
    typedef enum logic [1:0] {
        ORIENT_COLLINEAR = 2'd0,
        ORIENT_CW        = 2'd1,
        ORIENT_CCW       = 2'd2
    } t_orient;

    // Number of orientation tests per segment pair.
    localparam int NUM_ORIENT = 4;

    // Point slots held by the pipeline.
    localparam logic [1:0] PT_FIRST_START  = 2'd0;
    localparam logic [1:0] PT_FIRST_END    = 2'd1;
    localparam logic [1:0] PT_SECOND_START = 2'd2;
    localparam logic [1:0] PT_SECOND_END   = 2'd3;

    // Each test k uses the triple (p, q, r). The segment p-q is the one that
    // is tested against, and r is also the point checked against its box.
    localparam logic [1:0] ORI_P [NUM_ORIENT] = '{
        PT_FIRST_START, PT_FIRST_START, PT_SECOND_START, PT_SECOND_START
    };
    localparam logic [1:0] ORI_Q [NUM_ORIENT] = '{
        PT_FIRST_END, PT_FIRST_END, PT_SECOND_END, PT_SECOND_END
    };
    localparam logic [1:0] ORI_R [NUM_ORIENT] = '{
        PT_SECOND_START, PT_SECOND_END, PT_FIRST_START, PT_FIRST_END
    };

endpackage

`default_nettype wire

// ===== hdl/sit_in_if.sv =====
// Input channel: valid/ready handshake carrying one segment pair per beat.
// Depends on nothing; the coordinate width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

interface sit_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  first_start_x;
    logic signed [COORD_WIDTH-1:0]  first_start_y;
    logic signed [COORD_WIDTH-1:0]  first_dir_x;
    logic signed [COORD_WIDTH-1:0]  first_dir_y;
    logic signed [COORD_WIDTH-1:0]  second_start_x;
    logic signed [COORD_WIDTH-1:0]  second_start_y;
    logic signed [COORD_WIDTH-1:0]  second_dir_x;
    logic signed [COORD_WIDTH-1:0]  second_dir_y;

    modport source (
        output valid, first_start_x, first_start_y, first_dir_x, first_dir_y,
               second_start_x, second_start_y, second_dir_x, second_dir_y,
        input  ready
    );

    modport sink (
        input  valid, first_start_x, first_start_y, first_dir_x, first_dir_y,
               second_start_x, second_start_y, second_dir_x, second_dir_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/sit_out_if.sv =====
// Output channel: valid/ready handshake carrying one intersection flag per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sit_out_if;
    logic valid;
    logic ready;
    logic intersects;

    modport source (
        output valid, intersects,
        input  ready
    );

    modport sink (
        input  valid, intersects,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/segment_intersection_test_top.sv =====
// Five-stage pipelined segment intersection test (orientation method).
// Depends on sit_pkg, sit_in_if and sit_out_if.
//
//  Channel  | Port   | Direction | Beat payload
//  ---------+--------+-----------+-----------------------------------------
//  input    | i_in   | sink      | two segments: start x/y, direction x/y
//  output   | o_out  | source    | intersects flag, one per input beat
//
// One segment pair is accepted every cycle while the output is not stalled;
// each result passes through the five register stages (end points,
// differences and box checks, products, orientation signs, result).
// Reset is synchronous and active low; it clears the stage valid bits only.
// A stalled output holds the full stages next to it; stages behind a gap keep
// filling, so input ready stays high as long as some stage has room.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_test_top #(
    parameter int COORD_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sit_in_if.sink     i_in,
    sit_out_if.source  o_out
);

    // End points need one extra bit, differences two, products twice that.
    localparam int EW = COORD_WIDTH + 1;
    localparam int DW = COORD_WIDTH + 2;
    localparam int PW = 2 * DW;
    localparam int OW = PW + 1;
    localparam int NS = 5;

    typedef logic signed [EW-1:0] t_point_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [OW-1:0] t_cross;

    // Stage handshake: a stage loads when it is empty or its successor loads.
    logic [NS-1:0] r_v;
    logic [NS-1:0] stage_rdy;

    always_comb begin
        stage_rdy[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_v[k] || stage_rdy[k+1];
        end
    end

    assign i_in.ready = stage_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: start and end points of both segments.
    t_point_coord n1_x [4];
    t_point_coord n1_y [4];
    t_point_coord r1_x [4];
    t_point_coord r1_y [4];

    always_comb begin
        n1_x[sit_pkg::PT_FIRST_START]  = EW'(i_in.first_start_x);
        n1_y[sit_pkg::PT_FIRST_START]  = EW'(i_in.first_start_y);
        n1_x[sit_pkg::PT_FIRST_END]    = EW'(i_in.first_start_x) + EW'(i_in.first_dir_x);
        n1_y[sit_pkg::PT_FIRST_END]    = EW'(i_in.first_start_y) + EW'(i_in.first_dir_y);
        n1_x[sit_pkg::PT_SECOND_START] = EW'(i_in.second_start_x);
        n1_y[sit_pkg::PT_SECOND_START] = EW'(i_in.second_start_y);
        n1_x[sit_pkg::PT_SECOND_END]   = EW'(i_in.second_start_x) + EW'(i_in.second_dir_x);
        n1_y[sit_pkg::PT_SECOND_END]   = EW'(i_in.second_start_y) + EW'(i_in.second_dir_y);
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r1_x <= n1_x;
            r1_y <= n1_y;
        end
    end

    // Stage 2: coordinate differences for each test, and whether the tested
    // point lies inside the closed bounding box of the other segment.
    t_diff n2_dy1 [sit_pkg::NUM_ORIENT];
    t_diff n2_dx2 [sit_pkg::NUM_ORIENT];
    t_diff n2_dx1 [sit_pkg::NUM_ORIENT];
    t_diff n2_dy2 [sit_pkg::NUM_ORIENT];
    logic  [sit_pkg::NUM_ORIENT-1:0] n2_box;
    t_diff r2_dy1 [sit_pkg::NUM_ORIENT];
    t_diff r2_dx2 [sit_pkg::NUM_ORIENT];
    t_diff r2_dx1 [sit_pkg::NUM_ORIENT];
    t_diff r2_dy2 [sit_pkg::NUM_ORIENT];
    logic  [sit_pkg::NUM_ORIENT-1:0] r2_box;

    always_comb begin
        for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
            t_point_coord px, py, qx, qy, rx, ry;
            px = r1_x[sit_pkg::ORI_P[k]];
            py = r1_y[sit_pkg::ORI_P[k]];
            qx = r1_x[sit_pkg::ORI_Q[k]];
            qy = r1_y[sit_pkg::ORI_Q[k]];
            rx = r1_x[sit_pkg::ORI_R[k]];
            ry = r1_y[sit_pkg::ORI_R[k]];
            n2_dy1[k] = DW'(qy) - DW'(py);
            n2_dx2[k] = DW'(rx) - DW'(qx);
            n2_dx1[k] = DW'(qx) - DW'(px);
            n2_dy2[k] = DW'(ry) - DW'(qy);
            n2_box[k] = ((rx >= px && rx <= qx) || (rx >= qx && rx <= px))
                     && ((ry >= py && ry <= qy) || (ry >= qy && ry <= py));
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[1]) begin
            r2_dy1 <= n2_dy1;
            r2_dx2 <= n2_dx2;
            r2_dx1 <= n2_dx1;
            r2_dy2 <= n2_dy2;
            r2_box <= n2_box;
        end
    end

    // Stage 3: the two cross-product terms of each test, at full width.
    t_prod n3_pa [sit_pkg::NUM_ORIENT];
    t_prod n3_pb [sit_pkg::NUM_ORIENT];
    t_prod r3_pa [sit_pkg::NUM_ORIENT];
    t_prod r3_pb [sit_pkg::NUM_ORIENT];
    logic  [sit_pkg::NUM_ORIENT-1:0] r3_box;

    always_comb begin
        for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
            n3_pa[k] = PW'(r2_dy1[k]) * PW'(r2_dx2[k]);
            n3_pb[k] = PW'(r2_dx1[k]) * PW'(r2_dy2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[2]) begin
            r3_pa  <= n3_pa;
            r3_pb  <= n3_pb;
            r3_box <= r2_box;
        end
    end

    // Stage 4: subtract the terms and reduce the difference to its sign.
    sit_pkg::t_orient n4_ori [sit_pkg::NUM_ORIENT];
    sit_pkg::t_orient r4_ori [sit_pkg::NUM_ORIENT];
    logic [sit_pkg::NUM_ORIENT-1:0] r4_box;

    always_comb begin
        for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
            t_cross diff;
            diff = OW'(r3_pa[k]) - OW'(r3_pb[k]);
            if (diff == '0) begin
                n4_ori[k] = sit_pkg::ORIENT_COLLINEAR;
            end else if (diff[OW-1]) begin
                n4_ori[k] = sit_pkg::ORIENT_CCW;
            end else begin
                n4_ori[k] = sit_pkg::ORIENT_CW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[3]) begin
            r4_ori <= n4_ori;
            r4_box <= r3_box;
        end
    end

    // Stage 5: straddle test, or a collinear point inside the other box.
    logic n5_hit;
    logic r5_hit;

    always_comb begin
        logic coll_hit;
        coll_hit = 1'b0;
        for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
            coll_hit = coll_hit
                    || (r4_ori[k] == sit_pkg::ORIENT_COLLINEAR && r4_box[k]);
        end
        n5_hit = ((r4_ori[0] != r4_ori[1]) && (r4_ori[2] != r4_ori[3])) || coll_hit;
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[4]) begin
            r5_hit <= n5_hit;
        end
    end

    assign o_out.valid      = r_v[NS-1];
    assign o_out.intersects = r5_hit;

endmodule

`default_nettype wire

// ===== hdl/sit_checker.sv =====
// Port-level checks for segment_intersection_test_top, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module sit_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_intersects
);

    // A result beat that is not taken stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_intersects))
        else $error("stalled result beat changed or vanished");

    // The pipeline only refuses input when a finished result is held back.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused while the output side was not stalled");

    // A full pipeline frees a slot in the same cycle the result is taken.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input not ready although the result beat is taken");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

endmodule

bind segment_intersection_test_top sit_checker u_sit_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_intersects (o_out.intersects)
);

`default_nettype wire
